>>> sv/vdpr_pkg.sv
// ----------------------------------------------------------------------------
// vdpr_pkg
// Shared types, constants and the arctangent table of the phase rotator.
// ----------------------------------------------------------------------------
package vdpr_pkg;

    // Default antenna and polarisation counts.
    localparam int NUM_ANT_DEF = 4;
    localparam int NUM_POL_DEF = 4;

    // Port widths fixed by the sample format.
    localparam int POL_MAX  = 4;
    localparam int SMP_W    = 16;
    localparam int ANT_W    = 3;
    localparam int FREQ_W   = 32;
    localparam int DELAY_W  = 32;
    localparam int CFG_IDX_W = 3;

    // Phase path widths.
    localparam int DIFF_W   = 33;
    localparam int FRAC_W   = 44;
    localparam int PHASE_W  = 32;

    // CORDIC settings.
    localparam int CORDIC_STAGES = 16;
    localparam int CX_W     = 34;
    localparam int CZ_W     = 33;
    localparam int TRIG_W   = 18;
    localparam logic signed [CX_W-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] TRIG_ONE = 18'sd65536;

    // Samples of one beat, with the bad antenna flag.
    typedef struct packed {
        logic [POL_MAX-1:0][SMP_W-1:0] re;
        logic [POL_MAX-1:0][SMP_W-1:0] im;
        logic                          bad;
    } samp_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input int unsigned i);
        logic [29:0] v;
        case (i)
            0:  v = 30'd536870912;
            1:  v = 30'd316933406;
            2:  v = 30'd167458907;
            3:  v = 30'd85004756;
            4:  v = 30'd42667332;
            5:  v = 30'd21354465;
            6:  v = 30'd10679842;
            7:  v = 30'd5340247;
            8:  v = 30'd2670163;
            9:  v = 30'd1335087;
            10: v = 30'd667544;
            11: v = 30'd333772;
            12: v = 30'd166886;
            13: v = 30'd83443;
            14: v = 30'd41722;
            15: v = 30'd20861;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> sv/vdpr_phase.sv
// ----------------------------------------------------------------------------
// vdpr_phase
// Four-stage phase path: delay difference, split multiply, sum, negate and
// round to a 32-bit phase in units of 2^-32 turn.
// ----------------------------------------------------------------------------
module vdpr_phase
    import vdpr_pkg::*;
#(
    parameter int NUM_ANT = NUM_ANT_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_take,
    input  logic [ANT_W-1:0]                  ant_first,
    input  logic [ANT_W-1:0]                  ant_second,
    input  logic [FREQ_W-1:0]                 chan_freq,
    input  samp_t                             samp_in,
    input  logic [NUM_ANT-1:0][DELAY_W-1:0]   delays,
    output logic                              ph_valid,
    output logic [PHASE_W-1:0]                ph_phase,
    output samp_t                             ph_samp
);

    localparam int AIW = (NUM_ANT > 1) ? $clog2(NUM_ANT) : 1;

    logic                     v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DIFF_W-1:0] d_reg, d_next;
    logic [FREQ_W-1:0]        f_reg;
    samp_t                    s1_reg, s2_reg, s3_reg, s4_reg;
    samp_t                    s1_next;
    logic [FRAC_W-1:0]        m0_reg, m0_next;
    logic [27:0]              m1_reg, m1_next;
    logic [FRAC_W-1:0]        sum_reg, sum_next;
    logic [PHASE_W-1:0]       ph_reg, ph_next;
    logic [FRAC_W-1:0]        d44;
    logic [59:0]              p0;
    logic [43:0]              p1;
    logic [FRAC_W-1:0]        rnd;

    // Stage 1: pick the two delays and flag indices without a delay.
    always_comb
    begin
        s1_next = samp_in;
        s1_next.bad = (ant_first >= ANT_W'(NUM_ANT)) || (ant_second >= ANT_W'(NUM_ANT));
        d_next = DIFF_W'($signed(delays[ant_second[AIW-1:0]]))
               - DIFF_W'($signed(delays[ant_first[AIW-1:0]]));
    end

    // Stage 2: low 44 bits of the product, split on the frequency halves.
    assign d44 = {{(FRAC_W-DIFF_W){d_reg[DIFF_W-1]}}, d_reg};
    assign p0  = d44 * f_reg[15:0];
    assign p1  = d44[27:0] * f_reg[31:16];
    assign m0_next = p0[FRAC_W-1:0];
    assign m1_next = p1[27:0];

    // Stage 3: combine the partial products modulo one turn.
    assign sum_next = m0_reg + {m1_reg, 16'd0};

    // Stage 4: negate and round half up to 2^-32 turn.
    assign rnd     = ~sum_reg + 44'd2049;
    assign ph_next = rnd[FRAC_W-1:12];

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= d_next;
            f_reg   <= chan_freq;
            s1_reg  <= s1_next;
            m0_reg  <= m0_next;
            m1_reg  <= m1_next;
            s2_reg  <= s1_reg;
            sum_reg <= sum_next;
            s3_reg  <= s2_reg;
            ph_reg  <= ph_next;
            s4_reg  <= s3_reg;
        end
    end

    assign ph_valid = v4_reg;
    assign ph_phase = ph_reg;
    assign ph_samp  = s4_reg;

endmodule

>>> sv/vdpr_cordic.sv
// ----------------------------------------------------------------------------
// vdpr_cordic
// Sixteen-stage pipelined CORDIC in rotation mode on the low 30 phase bits,
// one micro-rotation per register stage.
// ----------------------------------------------------------------------------
module vdpr_cordic
    import vdpr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   ph_valid,
    input  logic [PHASE_W-1:0]     ph_phase,
    input  samp_t                  ph_samp,
    output logic                   cd_valid,
    output logic signed [CX_W-1:0] cd_x,
    output logic signed [CX_W-1:0] cd_y,
    output logic [1:0]             cd_quad,
    output samp_t                  cd_samp
);

    logic signed [CX_W-1:0] x_reg [0:CORDIC_STAGES-1];
    logic signed [CX_W-1:0] y_reg [0:CORDIC_STAGES-1];
    logic signed [CZ_W-1:0] z_reg [0:CORDIC_STAGES-1];
    logic [1:0]             q_reg [0:CORDIC_STAGES-1];
    samp_t                  s_reg [0:CORDIC_STAGES-1];
    logic                   v_reg [0:CORDIC_STAGES-1];

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_stage
            logic signed [CX_W-1:0] x_in, y_in, dx, dy, x_next, y_next;
            logic signed [CZ_W-1:0] z_in, z_next, at;
            logic [1:0]             q_in;
            samp_t                  s_in;
            logic                   v_in;

            // Stage input: the phase path for the first, the previous stage else.
            if (gi == 0)
            begin : g_first
                assign x_in = CORDIC_X0;
                assign y_in = '0;
                assign z_in = {3'b000, ph_phase[29:0]};
                assign q_in = ph_phase[31:30];
                assign s_in = ph_samp;
                assign v_in = ph_valid;
            end
            else
            begin : g_next
                assign x_in = x_reg[gi-1];
                assign y_in = y_reg[gi-1];
                assign z_in = z_reg[gi-1];
                assign q_in = q_reg[gi-1];
                assign s_in = s_reg[gi-1];
                assign v_in = v_reg[gi-1];
            end

            // One micro-rotation toward zero residual angle.
            assign dx = y_in >>> gi;
            assign dy = x_in >>> gi;
            assign at = $signed({3'b000, atan_turn(gi)});

            always_comb
            begin
                if (!z_in[CZ_W-1])
                begin
                    x_next = x_in - dx;
                    y_next = y_in + dy;
                    z_next = z_in - at;
                end
                else
                begin
                    x_next = x_in + dx;
                    y_next = y_in - dy;
                    z_next = z_in + at;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[gi] <= 1'b0;
                end
                else if (en)
                begin
                    v_reg[gi] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[gi] <= x_next;
                    y_reg[gi] <= y_next;
                    z_reg[gi] <= z_next;
                    q_reg[gi] <= q_in;
                    s_reg[gi] <= s_in;
                end
            end
        end
    endgenerate

    assign cd_valid = v_reg[CORDIC_STAGES-1];
    assign cd_x     = x_reg[CORDIC_STAGES-1];
    assign cd_y     = y_reg[CORDIC_STAGES-1];
    assign cd_quad  = q_reg[CORDIC_STAGES-1];
    assign cd_samp  = s_reg[CORDIC_STAGES-1];

endmodule

>>> sv/vdpr_rotate.sv
// ----------------------------------------------------------------------------
// vdpr_rotate
// Quadrant fold and rounding of cos and sin, the complex multiplies, and the
// rounded, saturated output register.
// ----------------------------------------------------------------------------
module vdpr_rotate
    import vdpr_pkg::*;
#(
    parameter int NUM_POL = NUM_POL_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  cd_valid,
    input  logic signed [CX_W-1:0]                cd_x,
    input  logic signed [CX_W-1:0]                cd_y,
    input  logic [1:0]                            cd_quad,
    input  samp_t                                 cd_samp,
    output logic                                  rot_valid,
    output logic [POL_MAX-1:0][SMP_W-1:0]         rot_re,
    output logic [POL_MAX-1:0][SMP_W-1:0]         rot_im,
    output logic                                  rot_bad
);

    localparam int PROD_W = SMP_W + TRIG_W;
    localparam int ACC_W  = PROD_W + 1;

    logic                     vq_reg, vm_reg, vo_reg;
    logic signed [TRIG_W-1:0] c_reg, c_next, s_reg, s_next;
    samp_t                    sq_reg, sm_reg;
    logic signed [CX_W-1:0]   xr, yr;
    logic signed [TRIG_W-1:0] cq, sq;
    logic                     bad_reg;
    logic [POL_MAX-1:0][SMP_W-1:0] re_reg, im_reg;

    // Round to Q16 and fold the quadrant; bad baselines use a unit phasor.
    assign xr = cd_x + 34'sd8192;
    assign yr = cd_y + 34'sd8192;
    assign cq = xr[14 +: TRIG_W];
    assign sq = yr[14 +: TRIG_W];

    always_comb
    begin
        case (cd_quad)
            2'd0:
            begin
                c_next = cq;
                s_next = sq;
            end
            2'd1:
            begin
                c_next = -sq;
                s_next = cq;
            end
            2'd2:
            begin
                c_next = -cq;
                s_next = -sq;
            end
            default:
            begin
                c_next = sq;
                s_next = -cq;
            end
        endcase
        if (cd_samp.bad)
        begin
            c_next = TRIG_ONE;
            s_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vq_reg <= 1'b0;
            vm_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            vq_reg <= cd_valid;
            vm_reg <= vq_reg;
            vo_reg <= vm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg   <= c_next;
            s_reg   <= s_next;
            sq_reg  <= cd_samp;
            sm_reg  <= sq_reg;
            bad_reg <= sm_reg.bad;
        end
    end

    // One lane per polarisation: multiply stage, then round and saturate.
    genvar gp;
    generate
        for (gp = 0; gp < POL_MAX; gp++)
        begin : g_pol
            if (gp < NUM_POL)
            begin : g_used
                logic signed [PROD_W-1:0] ac_reg, bs_reg, as_reg, bc_reg;
                logic signed [ACC_W-1:0]  re_sum, im_sum;
                logic signed [ACC_W-17:0] re_sh, im_sh;
                logic [SMP_W-1:0]         re_sat, im_sat;

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        ac_reg <= $signed(sq_reg.re[gp]) * c_reg;
                        bs_reg <= $signed(sq_reg.im[gp]) * s_reg;
                        as_reg <= $signed(sq_reg.re[gp]) * s_reg;
                        bc_reg <= $signed(sq_reg.im[gp]) * c_reg;
                    end
                end

                assign re_sum = ACC_W'(ac_reg) - ACC_W'(bs_reg) + 35'sd32768;
                assign im_sum = ACC_W'(as_reg) + ACC_W'(bc_reg) + 35'sd32768;
                assign re_sh  = re_sum[ACC_W-1:16];
                assign im_sh  = im_sum[ACC_W-1:16];

                always_comb
                begin
                    if (re_sh > 19'sd32767)
                        re_sat = 16'h7FFF;
                    else if (re_sh < -19'sd32768)
                        re_sat = 16'h8000;
                    else
                        re_sat = re_sh[SMP_W-1:0];
                    if (im_sh > 19'sd32767)
                        im_sat = 16'h7FFF;
                    else if (im_sh < -19'sd32768)
                        im_sat = 16'h8000;
                    else
                        im_sat = im_sh[SMP_W-1:0];
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        re_reg[gp] <= re_sat;
                        im_reg[gp] <= im_sat;
                    end
                end
            end
            else
            begin : g_unused
                assign re_reg[gp] = '0;
                assign im_reg[gp] = '0;
            end
        end
    endgenerate

    assign rot_valid = vo_reg;
    assign rot_re    = re_reg;
    assign rot_im    = im_reg;
    assign rot_bad   = bad_reg;

endmodule

>>> sv/visibility_delay_phase_rotator.sv
// ----------------------------------------------------------------------------
// visibility_delay_phase_rotator
// Rotates each visibility sample by the phase of its baseline delay.
// ----------------------------------------------------------------------------
// Usage:
// Input channel in_valid/in_stall carries one beat per visibility channel
// sample: two antenna indices, the channel frequency and four complex
// polarisation samples. Output channel out_valid/out_stall returns one beat
// per input beat, in order, with the rotated samples and bad_antenna.
// Per-antenna delays are written through cfg_wr_en/cfg_index/cfg_data; the
// user must do so only while the block is idle, which the block does not
// enforce; indices at or above NUM_ANT are ignored. Beats pass through the
// phase path, the CORDIC stages and the rotation and output registers, one
// beat per cycle unless the output stalls; every stage is a register with its
// own valid bit. Reset clears all valid bits and the delays to zero.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; bubbles are held as well.
// ----------------------------------------------------------------------------
module visibility_delay_phase_rotator
    import vdpr_pkg::*;
#(
    parameter int NUM_ANT = NUM_ANT_DEF,
    parameter int NUM_POL = NUM_POL_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [DELAY_W-1:0]       cfg_data,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ANT_W-1:0]         ant_first,
    input  logic [ANT_W-1:0]         ant_second,
    input  logic [FREQ_W-1:0]        chan_freq,
    input  logic signed [SMP_W-1:0]  in_re_0,
    input  logic signed [SMP_W-1:0]  in_im_0,
    input  logic signed [SMP_W-1:0]  in_re_1,
    input  logic signed [SMP_W-1:0]  in_im_1,
    input  logic signed [SMP_W-1:0]  in_re_2,
    input  logic signed [SMP_W-1:0]  in_im_2,
    input  logic signed [SMP_W-1:0]  in_re_3,
    input  logic signed [SMP_W-1:0]  in_im_3,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [SMP_W-1:0]  out_re_0,
    output logic signed [SMP_W-1:0]  out_im_0,
    output logic signed [SMP_W-1:0]  out_re_1,
    output logic signed [SMP_W-1:0]  out_im_1,
    output logic signed [SMP_W-1:0]  out_re_2,
    output logic signed [SMP_W-1:0]  out_im_2,
    output logic signed [SMP_W-1:0]  out_re_3,
    output logic signed [SMP_W-1:0]  out_im_3,
    output logic                     bad_antenna
);

    localparam int AIW = (NUM_ANT > 1) ? $clog2(NUM_ANT) : 1;

    logic [NUM_ANT-1:0][DELAY_W-1:0] delay_reg;
    logic                            en;
    samp_t                           samp_in, ph_samp, cd_samp;
    logic                            ph_valid, cd_valid, rot_valid;
    logic [PHASE_W-1:0]              ph_phase;
    logic signed [CX_W-1:0]          cd_x, cd_y;
    logic [1:0]                      cd_quad;
    logic [POL_MAX-1:0][SMP_W-1:0]   rot_re, rot_im;

    // Delay registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= '0;
        end
        else if (cfg_wr_en && (cfg_index < CFG_IDX_W'(NUM_ANT)))
        begin
            delay_reg[cfg_index[AIW-1:0]] <= cfg_data;
        end
    end

    // The pipeline moves unless a finished beat is held by the receiver.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        samp_in.re  = {in_re_3, in_re_2, in_re_1, in_re_0};
        samp_in.im  = {in_im_3, in_im_2, in_im_1, in_im_0};
        samp_in.bad = 1'b0;
    end

    vdpr_phase #(.NUM_ANT(NUM_ANT)) u_phase (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .in_take    (in_valid),
        .ant_first  (ant_first),
        .ant_second (ant_second),
        .chan_freq  (chan_freq),
        .samp_in    (samp_in),
        .delays     (delay_reg),
        .ph_valid   (ph_valid),
        .ph_phase   (ph_phase),
        .ph_samp    (ph_samp)
    );

    vdpr_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .ph_valid (ph_valid),
        .ph_phase (ph_phase),
        .ph_samp  (ph_samp),
        .cd_valid (cd_valid),
        .cd_x     (cd_x),
        .cd_y     (cd_y),
        .cd_quad  (cd_quad),
        .cd_samp  (cd_samp)
    );

    vdpr_rotate #(.NUM_POL(NUM_POL)) u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cd_valid  (cd_valid),
        .cd_x      (cd_x),
        .cd_y      (cd_y),
        .cd_quad   (cd_quad),
        .cd_samp   (cd_samp),
        .rot_valid (rot_valid),
        .rot_re    (rot_re),
        .rot_im    (rot_im),
        .rot_bad   (bad_antenna)
    );

    assign out_valid = rot_valid;
    assign out_re_0  = rot_re[0];
    assign out_im_0  = rot_im[0];
    assign out_re_1  = rot_re[1];
    assign out_im_1  = rot_im[1];
    assign out_re_2  = rot_re[2];
    assign out_im_2  = rot_im[2];
    assign out_re_3  = rot_re[3];
    assign out_im_3  = rot_im[3];

endmodule

>>> sv/vdpr_checker.sv
// ----------------------------------------------------------------------------
// vdpr_checker
// Port-level checks of the phase rotator, bound to the top level.
// ----------------------------------------------------------------------------
module vdpr_checker
    import vdpr_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_stall,
    input logic                    out_valid,
    input logic                    out_stall,
    input logic signed [SMP_W-1:0] out_re_0,
    input logic                    bad_antenna
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_re_0) && $stable(bad_antenna))
        else $error("stalled output beat changed");

    // Input back-pressure only comes from a held output beat.
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall without held output beat");

    // No result beat follows a cycle spent in reset.
    a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid after reset cycle");

    // No result beat is valid when reset is first seen released.
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("output beat right after reset");

endmodule

bind visibility_delay_phase_rotator vdpr_checker u_vdpr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_re_0    (out_re_0),
    .bad_antenna (bad_antenna)
);

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the visibility delay phase rotator. Beats are driven
// from a directed table and then from random phases with several sets of
// antenna delays. An independent fixed-point predictor (delay phase, CORDIC,
// rounding and saturation) gives the expected result of each non-passthru beat.
// ----------------------------------------------------------------------------
module testbench;
    import vdpr_pkg::*;

    localparam int ANTS = 4;
    localparam int IDLE_WAIT = 40;

    typedef struct packed {
        logic [ANT_W-1:0]                  ant_a;
        logic [ANT_W-1:0]                  ant_b;
        logic [FREQ_W-1:0]                 freq;
        logic [POL_MAX-1:0][SMP_W-1:0]     re;
        logic [POL_MAX-1:0][SMP_W-1:0]     im;
    } vis_t;

    typedef struct packed {
        logic [POL_MAX-1:0][SMP_W-1:0]     re;
        logic [POL_MAX-1:0][SMP_W-1:0]     im;
        logic                              bad;
    } rot_t;

    typedef struct packed {
        vis_t v;
        logic passthru;
    } row_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam longint ATAN_TURN [CORDIC_STAGES] = '{
        536870912, 316933406, 167458907, 85004756, 42667332, 21354465,
        10679842, 5340247, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [DELAY_W-1:0]      cfg_data;
    logic                    in_valid;
    logic                    in_stall;
    logic [ANT_W-1:0]        ant_first;
    logic [ANT_W-1:0]        ant_second;
    logic [FREQ_W-1:0]       chan_freq;
    logic signed [SMP_W-1:0] in_re_0, in_im_0, in_re_1, in_im_1;
    logic signed [SMP_W-1:0] in_re_2, in_im_2, in_re_3, in_im_3;
    logic                    out_valid;
    logic                    out_stall;
    logic signed [SMP_W-1:0] out_re_0, out_im_0, out_re_1, out_im_1;
    logic signed [SMP_W-1:0] out_re_2, out_im_2, out_re_3, out_im_3;
    logic                    bad_antenna;

    logic signed [DELAY_W-1:0] delay_copy [ANTS];
    rot_t  rotated_q[$];
    int    mismatches;
    int    beats_checked;
    bit    idling_on;
    int    stall_left;
    row_t  directed [$];

    visibility_delay_phase_rotator uut (.*);

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run.
    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

    // Expected rotation of one beat under the current delays.
    function automatic rot_t rotate_expected(input vis_t v);
        rot_t   r;
        longint dd, x, y, z, dx, dy, cq, sq, cs, sn, a, b, tr, ti;
        logic [63:0] prod, frac;
        logic [31:0] ph;
        r.bad = (v.ant_a >= ANTS) || (v.ant_b >= ANTS);
        cs = 65536;
        sn = 0;
        if (!r.bad)
        begin
            dd = longint'(delay_copy[v.ant_b[1:0]]) - longint'(delay_copy[v.ant_a[1:0]]);
            prod = dd * longint'({32'd0, v.freq});
            frac = (64'd0 - prod) & ((64'd1 << 44) - 1);
            ph = 32'((frac + 64'd2048) >> 12);
            x = 652032874;
            y = 0;
            z = longint'(ph[29:0]);
            for (int i = 0; i < CORDIC_STAGES; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx; y = y + dy; z = z - ATAN_TURN[i];
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + ATAN_TURN[i];
                end
            end
            cq = (x + 8192) >>> 14;
            sq = (y + 8192) >>> 14;
            case (ph[31:30])
                2'd0: begin cs = cq;  sn = sq;  end
                2'd1: begin cs = -sq; sn = cq;  end
                2'd2: begin cs = -cq; sn = -sq; end
                default: begin cs = sq; sn = -cq; end
            endcase
        end
        for (int p = 0; p < POL_MAX; p++)
        begin
            a = longint'($signed(v.re[p]));
            b = longint'($signed(v.im[p]));
            if (r.bad)
            begin
                tr = a; ti = b;
            end
            else
            begin
                tr = (a * cs - b * sn + 32768) >>> 16;
                ti = (a * sn + b * cs + 32768) >>> 16;
                tr = (tr > 32767) ? 32767 : ((tr < -32768) ? -32768 : tr);
                ti = (ti > 32767) ? 32767 : ((ti < -32768) ? -32768 : ti);
            end
            r.re[p] = 16'(tr);
            r.im[p] = 16'(ti);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Output side: random stall bursts and the check of every accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        rot_t want;
        rot_t got;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                got.re = {out_re_3, out_re_2, out_re_1, out_re_0};
                got.im = {out_im_3, out_im_2, out_im_1, out_im_0};
                got.bad = bad_antenna;
                beats_checked++;
                if (rotated_q.size() == 0)
                    report_mismatch("unexpected beat", 0, 0);
                else
                begin
                    want = rotated_q.pop_front();
                    for (int p = 0; p < POL_MAX; p++)
                    begin
                        if (got.re[p] !== want.re[p])
                            report_mismatch($sformatf("out_re_%0d", p),
                                $signed(got.re[p]), $signed(want.re[p]));
                        if (got.im[p] !== want.im[p])
                            report_mismatch($sformatf("out_im_%0d", p),
                                $signed(got.im[p]), $signed(want.im[p]));
                    end
                    if (got.bad !== want.bad)
                        report_mismatch("bad_antenna", got.bad, want.bad);
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Send one beat, with an optional gap first, and record its expectation.
    task automatic send_beat(input vis_t v, input bit passthru);
        rot_t r;
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        ant_first  <= v.ant_a;
        ant_second <= v.ant_b;
        chan_freq  <= v.freq;
        {in_re_3, in_re_2, in_re_1, in_re_0} <= v.re;
        {in_im_3, in_im_2, in_im_1, in_im_0} <= v.im;
        do @(posedge clk); while (in_stall);
        if (passthru)
        begin
            // Bad antenna: samples come back unchanged with the flag set.
            r.re = v.re;
            r.im = v.im;
            r.bad = 1'b1;
        end
        else
            r = rotate_expected(v);
        rotated_q.push_back(r);
    endtask

    // Wait until every result has come back and the pipeline has drained.
    task automatic wait_idle();
        int n;
        n = 0;
        in_valid <= 1'b0;
        while (rotated_q.size() != 0)
        begin
            @(posedge clk);
            n++;
            if (n > 200000)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    // Load all four delays, plus one write to an unused index.
    task automatic load_delays(input logic [31:0] d0, input logic [31:0] d1,
                               input logic [31:0] d2, input logic [31:0] d3);
        logic [31:0] vals [ANTS];
        logic [CFG_IDX_W-1:0] junk;
        vals = '{d0, d1, d2, d3};
        for (int i = 0; i < ANTS; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= vals[i];
            delay_copy[i] = vals[i];
            @(posedge clk);
        end
        // Indices past the last antenna must be ignored.
        junk = CFG_IDX_W'($urandom_range(ANTS, 7));
        cfg_index <= junk;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic row_t mk_row(input int a, input int b, input logic [31:0] f,
                                    input logic [15:0] r0, input logic [15:0] i0,
                                    input logic [15:0] r1, input logic [15:0] i1,
                                    input logic [15:0] r2, input logic [15:0] i2,
                                    input logic [15:0] r3, input logic [15:0] i3,
                                    input bit passthru);
        row_t w;
        w.v.ant_a = ANT_W'(a);
        w.v.ant_b = ANT_W'(b);
        w.v.freq = f;
        w.v.re = {r3, r2, r1, r0};
        w.v.im = {i3, i2, i1, i0};
        w.passthru = passthru;
        return w;
    endfunction

    function automatic logic [15:0] rand_smp();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : -1);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vis_t rand_vis();
        vis_t v;
        if ($urandom_range(0, 9) == 0)
        begin
            v.ant_a = ANT_W'($urandom_range(0, 7));
            v.ant_b = ANT_W'($urandom_range(0, 7));
        end
        else
        begin
            v.ant_a = ANT_W'($urandom_range(0, ANTS - 1));
            v.ant_b = ANT_W'($urandom_range(0, ANTS - 1));
        end
        case ($urandom_range(0, 5))
            0: v.freq = $urandom_range(0, 255);
            1: v.freq = 32'hFFFF_FFFF - $urandom_range(0, 255);
            default: v.freq = $urandom;
        endcase
        for (int p = 0; p < POL_MAX; p++)
        begin
            v.re[p] = rand_smp();
            v.im[p] = rand_smp();
        end
        return v;
    endfunction

    function automatic logic [31:0] rand_delay();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 4095)) - 2048);
            default: return $urandom;
        endcase
    endfunction

    // Main sequence.
    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        ant_first = '0;
        ant_second = '0;
        chan_freq = '0;
        {in_re_0, in_im_0, in_re_1, in_im_1} = '0;
        {in_re_2, in_im_2, in_re_3, in_im_3} = '0;
        mismatches = 0;
        beats_checked = 0;
        idling_on = 1'b1;
        for (int i = 0; i < ANTS; i++)
            delay_copy[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats with zero delays straight after reset.
        directed.push_back(mk_row(0, 1, 32'h0100_0000, 16'h4000, 16'h0000, 16'h7FFF,
            16'h8000, 16'h8000, 16'h7FFF, 16'h0001, 16'hFFFF, 0));
        directed.push_back(mk_row(4, 0, 32'h1234_5678, 16'h7FFF, 16'h8000, 16'h1234,
            16'hEDCB, 16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 1));
        directed.push_back(mk_row(0, 7, 32'hFFFF_FFFF, 16'h8000, 16'h8000, 16'h7FFF,
            16'h7FFF, 16'h0000, 16'h0000, 16'h5555, 16'hAAAA, 1));
        foreach (directed[k])
            send_beat(directed[k].v, directed[k].passthru);
        wait_idle();

        // Directed beats with extreme and quarter-turn delays.
        load_delays(32'h7FFF_FFFF, 32'h8000_0000, 32'h0010_0000, 32'h0000_0000);
        directed.delete();
        directed.push_back(mk_row(0, 1, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
            16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0));
        directed.push_back(mk_row(1, 0, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFF, 16'h8000,
            16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 0));
        directed.push_back(mk_row(3, 2, 32'h0040_0000, 16'h4000, 16'h0000, 16'h0000,
            16'h4000, 16'hC000, 16'h0000, 16'h0000, 16'hC000, 0));
        directed.push_back(mk_row(3, 2, 32'h0080_0000, 16'h4000, 16'h0000, 16'h0000,
            16'h4000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 0));
        directed.push_back(mk_row(3, 2, 32'h00C0_0000, 16'h4000, 16'h0000, 16'h0000,
            16'h4000, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000, 0));
        directed.push_back(mk_row(2, 3, 32'h0020_0000, 16'h7FFF, 16'h7FFF, 16'h8000,
            16'h8000, 16'h1000, 16'h2000, 16'hFFFF, 16'h0001, 0));
        directed.push_back(mk_row(2, 2, 32'hDEAD_BEEF, 16'h7FFF, 16'h8000, 16'h0001,
            16'hFFFF, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 0));
        directed.push_back(mk_row(1, 3, 32'h0000_0000, 16'h8000, 16'h8000, 16'h7FFF,
            16'h7FFF, 16'h0002, 16'hFFFE, 16'h0100, 16'hFF00, 0));
        directed.push_back(mk_row(7, 7, 32'h0000_0001, 16'h0000, 16'hFFFF, 16'h8000,
            16'h7FFF, 16'h2468, 16'h1357, 16'hFFFF, 16'h0000, 1));
        directed.push_back(mk_row(3, 5, 32'h8000_0000, 16'h0001, 16'h0002, 16'h0003,
            16'h0004, 16'h0005, 16'h0006, 16'h0007, 16'h0008, 1));
        directed.push_back(mk_row(6, 1, 32'h0000_0000, 16'hFFF0, 16'h000F, 16'h7FFF,
            16'h8000, 16'h0000, 16'h0000, 16'h1111, 16'hEEEE, 1));
        foreach (directed[k])
            send_beat(directed[k].v, directed[k].passthru);
        wait_idle();

        // Random phases, each under its own delays; the last one without idling.
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: load_delays(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
                1: load_delays(32'h0, 32'h0, 32'h0, 32'h0);
                default: load_delays(rand_delay(), rand_delay(), rand_delay(), rand_delay());
            endcase
            if (ph == 5)
                idling_on = 1'b0;
            repeat ((ph == 5) ? 150 : 170)
                send_beat(rand_vis(), 0);
            wait_idle();
        end

        $display("Checked %0d beats: directed table plus six random delay phases,",
            beats_checked);
        $display("with bad antenna indices, extreme delays and random stalls; %0d mismatches.",
            mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> visibility_delay_phase_rotator.f
sv/vdpr_pkg.sv
sv/vdpr_phase.sv
sv/vdpr_cordic.sv
sv/vdpr_rotate.sv
sv/visibility_delay_phase_rotator.sv
sv/vdpr_checker.sv
tb/testbench.sv
